/* design/dqir_pkg.sv */
`default_nettype none

package dqir_pkg;

  // Ring size; must be a power of two so pointer wrap is plain truncation
  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COUNT_W = ADDR_W + 1;
  localparam int FIELD_W = 16;
  localparam int ENTRY_W = 3 * FIELD_W;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Record: workers in the low bits, then work time, then productivity
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    entry_t            wdata;
  } mem_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
    logic               is_read;
  } result_t;

endpackage

`default_nettype wire

/* design/dqir_ram.sv */
`default_nettype none

module dqir_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* design/dqir_ctrl.sv */
`default_nettype none

module dqir_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic [dqir_pkg::CMD_W-1:0]  command,
  input  wire dqir_pkg::entry_t         entry,
  input  wire logic [dqir_pkg::ADDR_W-1:0] read_index,
  output dqir_pkg::mem_req_t            mem_req,
  output dqir_pkg::result_t             res
);
  import dqir_pkg::*;

  logic [ADDR_W-1:0]  head, head_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               full, empty;

  assign full  = (count == COUNT_W'(DEPTH));
  assign empty = (count == '0);

  // Command decode: pointer/count update and the one memory access
  always_comb begin
    head_next     = head;
    count_next    = count;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = head;
    mem_req.wdata = entry;
    res.status    = ST_OK;
    res.is_read   = 1'b0;
    case (command)
      CMD_PUSH_BACK: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          mem_req.we   = accept;
          mem_req.addr = head + count[ADDR_W-1:0];
          count_next   = count + COUNT_W'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          head_next    = head - ADDR_W'(1);
          mem_req.we   = accept;
          mem_req.addr = head_next;
          count_next   = count + COUNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          count_next = count - COUNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          head_next  = head + ADDR_W'(1);
          count_next = count - COUNT_W'(1);
        end
      end
      CMD_READ: begin
        if ({1'b0, read_index} >= count) begin
          res.status = ST_RANGE;
        end else begin
          mem_req.re   = accept;
          mem_req.addr = head + read_index;
          res.is_read  = 1'b1;
        end
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
    res.count = count_next;
  end

  // Pointer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (accept) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count) && $stable(head))
    else $error("state moved without a transaction");

  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    accept && res.status != ST_OK |=> $stable(count) && $stable(head))
    else $error("refused command changed state");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.we && mem_req.re))
    else $error("read and write in one cycle");

endmodule

`default_nettype wire

/* design/double_ended_queue_with_index_read_top.sv */
`default_nettype none

// Channel  Dir  Bits  Contents (lowest bit first)
// s_*      in   64    tdata: entry_workers, entry_worktime, entry_productivity,
//                     read_index; tuser: command
// m_*      out  64    tdata: entry_count, read_workers, read_worktime,
//                     read_productivity; tuser: status
//
// Push, pop and refused commands give their result in the cycle after the transaction.
// A successful read first reads the memory, then loads the result register.
// rst is synchronous; queue comes up empty, memory contents are not cleared.
// s_tready drops while a read is in flight or the result register is held by
// a stalled m_tready; otherwise one command is taken per cycle.
module double_ended_queue_with_index_read_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // workers, worktime, productivity, read_index
  input  wire logic [2:0]  s_tuser,  // command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata,  // entry_count, workers, worktime, productivity
  output logic      [1:0]  m_tuser   // status
);
  import dqir_pkg::*;

  logic               accept;
  logic               rd_pending;
  mem_req_t           mem_req;
  result_t            res;
  entry_t             rdata;
  logic [STAT_W-1:0]  out_status;
  logic [COUNT_W-1:0] out_count;
  entry_t             out_data;

  assign s_tready = !rd_pending && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  dqir_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (s_tuser),
    .entry      (s_tdata[ENTRY_W-1:0]),
    .read_index (s_tdata[ENTRY_W+ADDR_W-1:ENTRY_W]),
    .mem_req    (mem_req),
    .res        (res)
  );

  dqir_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  // Result handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= accept && res.is_read;
      if (rd_pending || (accept && !res.is_read)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= res.status;
      out_count  <= res.count;
      out_data   <= '0;
    end
    if (rd_pending) begin
      out_data <= rdata;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {(64 - ENTRY_W - COUNT_W)'(0), out_data, out_count};

  a_pending_blocks: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> !s_tready && !m_tvalid)
    else $error("read in flight overlaps another transaction");

  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    accept && res.is_read |=> rd_pending ##1 m_tvalid)
    else $error("read result not delivered on time");

endmodule

`default_nettype wire
